// File: sv/acc8_pkg.sv
`timescale 1ns / 1ps

package acc8_pkg;

   typedef enum logic [1:0] {
      FUNC_TICK       = 2'd0,
      FUNC_WRITE      = 2'd1,
      FUNC_LOAD       = 2'd2,
      FUNC_SOFT_RESET = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      PH_FETCH = 2'd0,
      PH_EXEC  = 2'd1,
      PH_HALT  = 2'd2
   } phase_type;

   // top three instruction bits
   localparam logic [2:0] OP_LDA = 3'd0;
   localparam logic [2:0] OP_STA = 3'd1;
   localparam logic [2:0] OP_ADD = 3'd2;
   localparam logic [2:0] OP_SUB = 3'd3;
   localparam logic [2:0] OP_JMP = 3'd4;
   localparam logic [2:0] OP_JOM = 3'd5;
   localparam logic [2:0] OP_JOZ = 3'd6;
   localparam logic [2:0] OP_GRP = 3'd7;

   // low three bits inside the register group
   localparam logic [2:0] GRP_SWAP_B = 3'd0;
   localparam logic [2:0] GRP_SHIFT  = 3'd1;
   localparam logic [2:0] GRP_AND_B  = 3'd2;
   localparam logic [2:0] GRP_DEC    = 3'd3;
   localparam logic [2:0] GRP_NOT    = 3'd4;
   localparam logic [2:0] GRP_NOP    = 3'd5;
   localparam logic [2:0] GRP_SWAP_E = 3'd6;
   localparam logic [2:0] GRP_HALT   = 3'd7;

   localparam logic [5:0] RAM_START_RESET = 6'd16;

   typedef struct packed {
      func_type   func;
      logic [4:0] addr;
      logic [7:0] data;
   } req_type;

   typedef struct packed {
      logic [7:0] acc_value;
      logic [7:0] instr_value;
      logic [4:0] pc_value;
      logic       in_execute;
      logic       is_halted;
   } rsp_type;

   typedef struct packed {
      logic       we;
      logic [4:0] addr;
      logic [7:0] data;
   } store_wr_type;

endpackage

// File: sv/accumulator_cpu_8bit_step.sv
// A word accepted into the input register is processed into the result register once
// the result slot is free; result stalls hold it in the input register.
// Throughput: one word per cycle while results are not stalled; the machine state
// updates at the same edge that loads the result register.
// Reset (synchronous, active high): clears phase, counters, registers and all
// store bytes; ram_start returns to 16.
`timescale 1ns / 1ps

module accumulator_cpu_8bit_step #(
   parameter int PHASE_TICKS = 8,
   parameter int MEM_DEPTH   = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  acc8_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output acc8_pkg::rsp_type rsp_word,
   input  logic              csr_wr_en,
   input  logic [5:0]        csr_wr_data
);
   import acc8_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_type      in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff;
   logic [5:0]   ram_start_ff;
   logic         go;
   logic         req_accept;
   logic [4:0]   rd_addr;
   logic [7:0]   rd_data;
   store_wr_type wr;
   rsp_type      core_rsp;

   // advance when the result slot is free or being drained
   assign go         = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !go;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept ? 1'b1 : (go ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = go ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ram_start_ff <= RAM_START_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            ram_start_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= req_word;
      end
      if (go) begin
         rsp_ff <= core_rsp;
      end
   end

   acc8_core #(
      .PHASE_TICKS (PHASE_TICKS),
      .MEM_DEPTH   (MEM_DEPTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .item      (in_item_ff),
      .ram_start (ram_start_ff),
      .rd_data   (rd_data),
      .rd_addr   (rd_addr),
      .wr        (wr),
      .rsp       (core_rsp)
   );

   acc8_store #(
      .MEM_DEPTH (MEM_DEPTH)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_go_delivers: assert property (@(posedge clock) disable iff (reset)
      go |=> rsp_valid_ff)
      else $error("processed word produced no result");

   a_held_word: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !go) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("waiting input word lost or overwritten");

   a_phase_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.in_execute && rsp_ff.is_halted))
      else $error("execute and halt flagged together");

endmodule

// File: sv/acc8_store.sv
`timescale 1ns / 1ps

module acc8_store #(
   parameter int MEM_DEPTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  acc8_pkg::store_wr_type wr,
   input  logic [4:0]            rd_addr,
   output logic [7:0]            rd_data
);
   import acc8_pkg::*;

   localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   logic [7:0] mem_ff [MEM_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MEM_DEPTH; i++) begin
            mem_ff[i] <= '0;
         end
      end else if (wr.we) begin
         mem_ff[wr.addr[AW-1:0]] <= wr.data;
      end
   end

   // addresses arrive already reduced below the depth
   assign rd_data = mem_ff[rd_addr[AW-1:0]];

endmodule

// File: sv/acc8_core.sv
`timescale 1ns / 1ps

module acc8_core #(
   parameter int PHASE_TICKS = 8,
   parameter int MEM_DEPTH   = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   go,
   input  acc8_pkg::req_type      item,
   input  logic [5:0]             ram_start,
   input  logic [7:0]             rd_data,
   output logic [4:0]             rd_addr,
   output acc8_pkg::store_wr_type wr,
   output acc8_pkg::rsp_type      rsp
);
   import acc8_pkg::*;

   localparam int TW = $clog2(PHASE_TICKS);

   phase_type   phase_ff, phase_in;
   logic [TW-1:0] tick_ff, tick_in;
   logic [4:0]  pc_ff, pc_in;
   logic [7:0]  instr_ff, instr_in;
   logic [4:0]  mar_ff, mar_in;
   logic [7:0]  acc_ff, acc_in;
   logic [7:0]  reg_b_ff, reg_b_in;
   logic [7:0]  reg_e_ff, reg_e_in;

   logic [4:0]  mod_tbl [32];
   logic [4:0]  op_addr;
   logic [2:0]  op;
   logic [2:0]  grp;
   logic        last_tick;
   logic        is_tick;
   logic        do_fetch;
   logic        do_run;
   logic        halt_instr;

   // operand reduction table, built at elaboration
   for (genvar i = 0; i < 32; i++) begin : g_mod
      assign mod_tbl[i] = 5'(i % MEM_DEPTH);
   end

   assign op         = instr_ff[7:5];
   assign grp        = instr_ff[2:0];
   assign op_addr    = mod_tbl[instr_ff[4:0]];
   assign last_tick  = (tick_ff == TW'(PHASE_TICKS - 1));
   assign is_tick    = go && (item.func == FUNC_TICK);
   assign do_fetch   = is_tick && (phase_ff == PH_FETCH);
   assign do_run     = is_tick && (phase_ff == PH_EXEC) && last_tick;
   assign halt_instr = (op == OP_GRP) && (grp == GRP_HALT);
   assign rd_addr    = do_fetch ? pc_ff : op_addr;

   // phase sequencing
   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      if (go) begin
         case (item.func)
            FUNC_TICK: begin
               unique case (phase_ff)
                  PH_FETCH: begin
                     if (last_tick) begin
                        tick_in  = '0;
                        phase_in = PH_EXEC;
                     end else begin
                        tick_in = tick_ff + 1'b1;
                     end
                  end
                  PH_EXEC: begin
                     if (last_tick) begin
                        tick_in  = '0;
                        phase_in = halt_instr ? PH_HALT : PH_FETCH;
                     end else begin
                        tick_in = tick_ff + 1'b1;
                     end
                  end
                  PH_HALT: ;
                  default: begin
                     phase_in = PH_FETCH;
                     tick_in  = '0;
                  end
               endcase
            end
            FUNC_SOFT_RESET: begin
               phase_in = PH_FETCH;
               tick_in  = '0;
            end
            default: ;
         endcase
      end
   end

   // datapath
   always_comb begin
      pc_in    = pc_ff;
      instr_in = instr_ff;
      mar_in   = mar_ff;
      acc_in   = acc_ff;
      reg_b_in = reg_b_ff;
      reg_e_in = reg_e_ff;
      wr.we    = 1'b0;
      wr.addr  = item.addr;
      wr.data  = item.data;
      if (do_fetch) begin
         mar_in   = pc_ff;
         instr_in = rd_data;
         if (last_tick) begin
            pc_in = (pc_ff == 5'(MEM_DEPTH - 1)) ? '0 : pc_ff + 5'd1;
         end
      end else if (do_run) begin
         mar_in = op_addr;
         unique case (op)
            OP_LDA: acc_in = rd_data;
            OP_STA: begin
               wr.we   = ({1'b0, op_addr} >= ram_start);
               wr.addr = op_addr;
               wr.data = acc_ff;
            end
            OP_ADD: acc_in = acc_ff + rd_data;
            OP_SUB: acc_in = acc_ff - rd_data;
            OP_JMP: pc_in = op_addr;
            OP_JOM: if (acc_ff[7]) pc_in = op_addr;
            OP_JOZ: if (acc_ff == 8'd0) pc_in = op_addr;
            OP_GRP: begin
               unique case (grp)
                  GRP_SWAP_B: begin
                     acc_in   = reg_b_ff;
                     reg_b_in = acc_ff;
                  end
                  GRP_SHIFT:  acc_in = op_addr[4] ? {acc_ff[6:0], 1'b0}
                                                  : {1'b0, acc_ff[7:1]};
                  GRP_AND_B:  acc_in = acc_ff & reg_b_ff;
                  GRP_DEC:    acc_in = acc_ff - 8'd1;
                  GRP_NOT:    acc_in = ~acc_ff;
                  GRP_NOP:    ;
                  GRP_SWAP_E: begin
                     acc_in   = reg_e_ff;
                     reg_e_in = acc_ff;
                  end
                  GRP_HALT:   ;
               endcase
            end
         endcase
      end else if (go) begin
         case (item.func)
            FUNC_WRITE:      wr.we = ({1'b0, item.addr} < 6'(MEM_DEPTH));
            FUNC_LOAD:       acc_in = item.data;
            FUNC_SOFT_RESET: begin
               pc_in    = '0;
               instr_in = '0;
               acc_in   = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FETCH;
         tick_ff  <= '0;
         pc_ff    <= '0;
         instr_ff <= '0;
         mar_ff   <= '0;
         acc_ff   <= '0;
         reg_b_ff <= '0;
         reg_e_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         pc_ff    <= pc_in;
         instr_ff <= instr_in;
         mar_ff   <= mar_in;
         acc_ff   <= acc_in;
         reg_b_ff <= reg_b_in;
         reg_e_ff <= reg_e_in;
      end
   end

   assign rsp.acc_value   = acc_in;
   assign rsp.instr_value = instr_in;
   assign rsp.pc_value    = pc_in;
   assign rsp.in_execute  = (phase_in == PH_EXEC);
   assign rsp.is_halted   = (phase_in == PH_HALT);

   a_halt_tick_zero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HALT) |-> (tick_ff == '0))
      else $error("tick count not cleared while halted");

   a_halt_frozen: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HALT && is_tick) |=> ($stable(pc_ff) && $stable(acc_ff)
                                            && phase_ff == PH_HALT))
      else $error("tick changed state while halted");

   a_pc_in_range: assert property (@(posedge clock) disable iff (reset)
      go |-> ({1'b0, pc_in} < 6'(MEM_DEPTH)))
      else $error("program counter left the store");

endmodule
